### hdl/hsv_color_class_matcher_macros.svh
// ----------------------------------------------------------------------------
// hsv colour class matcher assertion macros
// shared concurrent assertion shorthands, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef HSV_COLOR_CLASS_MATCHER_MACROS_SVH
`define HSV_COLOR_CLASS_MATCHER_MACROS_SVH

// same-cycle implication
`define HCM_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HCM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/hcm_pkg.sv
// ----------------------------------------------------------------------------
// hsv colour class matcher package
// threshold register layout, class codes and fixed window constants
// ----------------------------------------------------------------------------
package hcm_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueRegW  = 9;
  localparam int unsigned PctRegW  = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_BALL_HUE_MAX     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BALL_SAT_MIN_PCT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BALL_VAL_MIN     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLUE_HUE_MIN     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BLUE_HUE_MAX     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BLUE_VAL_MAX     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_YELLOW_HUE_MIN   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_YELLOW_HUE_MAX   = 3'd7;

  // fixed goal windows
  localparam logic [3:0]       GOAL_SAT_NUM   = 4'd4;
  localparam logic [3:0]       GOAL_SAT_DEN   = 4'd10;
  localparam logic [6:0]       PCT_SCALE      = 7'd100;
  localparam logic [ChanW-1:0] BLUE_VAL_MIN   = 8'd20;
  localparam logic [ChanW-1:0] YELLOW_VAL_MIN = 8'd120;
  localparam logic [5:0]       SECTOR_DEG     = 6'd60;
  localparam logic [8:0]       FULL_TURN      = 9'd360;

  typedef enum logic [1:0] {
    CLS_BALL   = 2'd0,
    CLS_YELLOW = 2'd1,
    CLS_BLUE   = 2'd2
  } obj_class_e;

  typedef struct packed {
    logic [HueRegW-1:0] ball_hue_max;
    logic [PctRegW-1:0] ball_sat_min_pct;
    logic [ChanW-1:0]   ball_val_min;
    logic [HueRegW-1:0] blue_hue_min;
    logic [HueRegW-1:0] blue_hue_max;
    logic [ChanW-1:0]   blue_val_max;
    logic [HueRegW-1:0] yellow_hue_min;
    logic [HueRegW-1:0] yellow_hue_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ball_hue_max:     9'd35,
    ball_sat_min_pct: 7'd45,
    ball_val_min:     8'd65,
    blue_hue_min:     9'd186,
    blue_hue_max:     9'd240,
    blue_val_max:     8'd150,
    yellow_hue_min:   9'd45,
    yellow_hue_max:   9'd65
  };

endpackage

### hdl/hcm_cfg_regs.sv
// ----------------------------------------------------------------------------
// hcm threshold registers
// write-only bank of the eight class window thresholds
// ----------------------------------------------------------------------------
module hcm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hcm_pkg::CfgDataW-1:0]  cfg_data_i,
  output hcm_pkg::cfg_t                 cfg_o
);
  import hcm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BALL_HUE_MAX:     cfg_q.ball_hue_max     <= cfg_data_i;
        CFG_BALL_SAT_MIN_PCT: cfg_q.ball_sat_min_pct <= cfg_data_i[PctRegW-1:0];
        CFG_BALL_VAL_MIN:     cfg_q.ball_val_min     <= cfg_data_i[ChanW-1:0];
        CFG_BLUE_HUE_MIN:     cfg_q.blue_hue_min     <= cfg_data_i;
        CFG_BLUE_HUE_MAX:     cfg_q.blue_hue_max     <= cfg_data_i;
        CFG_BLUE_VAL_MAX:     cfg_q.blue_val_max     <= cfg_data_i[ChanW-1:0];
        CFG_YELLOW_HUE_MIN:   cfg_q.yellow_hue_min   <= cfg_data_i;
        CFG_YELLOW_HUE_MAX:   cfg_q.yellow_hue_max   <= cfg_data_i;
        default:              cfg_q                  <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/hcm_classify.sv
// ----------------------------------------------------------------------------
// hcm pixel classifier
// hue numerator, span and value of one pixel, tested against a class window
// by exact integer cross-multiplication
// ----------------------------------------------------------------------------
module hcm_classify (
  input  logic [hcm_pkg::ChanW-1:0] red_i,
  input  logic [hcm_pkg::ChanW-1:0] green_i,
  input  logic [hcm_pkg::ChanW-1:0] blue_i,
  input  logic [1:0]                cls_i,
  input  hcm_pkg::cfg_t             cfg_i,
  output logic                      match_o
);
  import hcm_pkg::*;

  logic [ChanW-1:0]   mx;
  logic [ChanW-1:0]   mn;
  logic [ChanW-1:0]   span;
  logic signed [11:0] sec;
  logic signed [17:0] hn_raw;
  logic [16:0]        span_turn;
  logic signed [17:0] hn_adj;
  logic [16:0]        hue;
  logic [HueRegW-1:0] hue_lo;
  logic [HueRegW-1:0] hue_hi;
  logic [16:0]        lo_prod;
  logic [16:0]        hi_prod;
  logic [14:0]        sat_lhs;
  logic [14:0]        sat_rhs;
  logic               val_ok;
  logic               cls_ok;
  logic               is_ball;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn) mn = blue_i;
  end

  assign span = mx - mn;

  // six-sector hue numerator over span
  always_comb begin
    priority if (red_i >= green_i && red_i >= blue_i) begin
      sec = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sec = $signed({3'b0, span, 1'b0}) + $signed({4'b0, blue_i})
          - $signed({4'b0, red_i});
    end else begin
      sec = $signed({2'b0, span, 2'b0}) + $signed({4'b0, red_i})
          - $signed({4'b0, green_i});
    end
  end

  assign hn_raw    = $signed({{6{sec[11]}}, sec}) * $signed({12'b0, SECTOR_DEG});
  assign span_turn = 17'(span) * 17'(FULL_TURN);
  assign hn_adj    = hn_raw[17] ? (hn_raw + $signed({1'b0, span_turn})) : hn_raw;
  assign hue       = hn_adj[16:0];

  // per-class window selection
  always_comb begin
    hue_lo  = '0;
    hue_hi  = '0;
    val_ok  = 1'b0;
    cls_ok  = 1'b0;
    is_ball = 1'b0;
    unique case (cls_i)
      CLS_BALL: begin
        is_ball = 1'b1;
        hue_hi  = cfg_i.ball_hue_max;
        val_ok  = mx > cfg_i.ball_val_min;
        cls_ok  = 1'b1;
      end
      CLS_YELLOW: begin
        hue_lo = cfg_i.yellow_hue_min;
        hue_hi = cfg_i.yellow_hue_max;
        val_ok = mx > YELLOW_VAL_MIN;
        cls_ok = 1'b1;
      end
      CLS_BLUE: begin
        hue_lo = cfg_i.blue_hue_min;
        hue_hi = cfg_i.blue_hue_max;
        val_ok = (mx > BLUE_VAL_MIN) && (mx < cfg_i.blue_val_max);
        cls_ok = 1'b1;
      end
      default: begin
        cls_ok = 1'b0;
      end
    endcase
  end

  assign lo_prod = 17'(hue_lo) * 17'(span);
  assign hi_prod = 17'(hue_hi) * 17'(span);

  assign sat_lhs = is_ball ? (15'(span) * 15'(PCT_SCALE)) : (15'(span) * 15'(GOAL_SAT_DEN));
  assign sat_rhs = is_ball ? (15'(cfg_i.ball_sat_min_pct) * 15'(mx))
                           : (15'(mx) * 15'(GOAL_SAT_NUM));

  assign match_o = cls_ok && val_ok && (hue > lo_prod) && (hue < hi_prod)
                && (sat_lhs > sat_rhs);

endmodule

### hdl/hsv_color_class_matcher.sv
// ----------------------------------------------------------------------------
// hsv colour class matcher
// tests one rgb pixel against the hue, saturation and value window of a
// chosen object class (ball, yellow goal, blue goal)
//
//   channel  direction  handshake                signals
//   pixel    in         in_valid_i / in_stall_o  red_i green_i blue_i object_class_i
//   result   out        out_valid_o / out_stall_i  is_match_o
//   config   in         cfg_we_i (no back-pressure) cfg_idx_i cfg_data_i
//
// one pixel per cycle sustained while the result side does not stall; a result is
// offered once its pixel has passed the input register and the result register
// reset loads the default thresholds and empties both registers
// in_stall_o is raised only when both registers hold a pixel and the
// result side stalls
// ----------------------------------------------------------------------------
`include "hsv_color_class_matcher_macros.svh"

module hsv_color_class_matcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hcm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hcm_pkg::ChanW-1:0]     red_i,
  input  logic [hcm_pkg::ChanW-1:0]     green_i,
  input  logic [hcm_pkg::ChanW-1:0]     blue_i,
  input  logic [1:0]                    object_class_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          is_match_o
);
  import hcm_pkg::*;

  cfg_t             cfg;
  logic             in_vld_q;
  logic [ChanW-1:0] red_q;
  logic [ChanW-1:0] green_q;
  logic [ChanW-1:0] blue_q;
  logic [1:0]       cls_q;
  logic             out_vld_q;
  logic             match_q;
  logic             match_d;
  logic             res_free;
  logic             advance;
  logic             in_xfer;

  hcm_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hcm_classify u_classify (
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .cls_i   (cls_q),
    .cfg_i   (cfg),
    .match_o (match_d)
  );

  assign res_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      cls_q   <= object_class_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      match_q <= match_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign is_match_o  = match_q;

  `HCM_ASSERT_NOW(a_stall_only_when_full, in_stall_o, in_vld_q && out_vld_q && out_stall_i, "input stalled while a register is free")
  `HCM_ASSERT_NEXT(a_pixel_reaches_result, advance, out_vld_q, "pixel lost between input and result register")
  `HCM_ASSERT_NEXT(a_held_pixel_kept, in_vld_q && !res_free, in_vld_q && $stable(red_q) && $stable(cls_q), "held pixel dropped or changed")
  `HCM_ASSERT_NEXT(a_black_never_matches, advance && red_q == '0 && green_q == '0 && blue_q == '0, !is_match_o, "black pixel reported as a match")

endmodule
